// ===== sv/bump_pkg.sv =====
// ----------------------------------------------------------------------------
// bump_pkg
// Shared widths, codes and defaults of the bump arena with its id registry.
// ----------------------------------------------------------------------------
`default_nettype none

package bump_pkg;

   // Parameter defaults
   localparam int KINDS_DEF         = 4;
   localparam int MAX_IDS_DEF       = 256;
   localparam int MAX_POOL_DEF      = 65536;
   localparam int POINTER_BYTES_DEF = 4;

   // Number of kinds that have a count register
   localparam int CFG_KINDS = 4;

   // Field widths
   localparam int KIND_W      = 8;
   localparam int ID_W        = 16;
   localparam int REQ_BYTES_W = 32;
   localparam int ADDR_W      = 16;
   localparam int BYTES_W     = 17;
   localparam int COUNT_W     = 9;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 17;

   // Generation tag stored per registry mark
   localparam int EPOCH_W = 8;

   localparam logic [ID_W-1:0] ID_NONE = '1;

   // Round-up term of the 4-byte alignment
   localparam int ALIGN_ADD = 3;

   typedef enum logic [1:0] {
      OP_CLOSE = 2'd0,
      OP_OPEN  = 2'd1,
      OP_ALLOC = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_TOO_BIG = 3'd1,
      ST_OOB     = 3'd2,
      ST_DUP     = 3'd3,
      ST_NO_MEM  = 3'd4
   } status_type;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_SIZE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_0   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_1   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_3   = 3'd4;

endpackage

`default_nettype wire

// ===== sv/bump_ifs.sv =====
// ----------------------------------------------------------------------------
// bump_ifs
// Request and response channels of the bump arena, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bump_req_if;
   logic                                    valid;
   logic                                    ready;
   bump_pkg::opcode_type                    opcode;
   logic [bump_pkg::KIND_W-1:0]             kind;
   logic [bump_pkg::ID_W-1:0]               item_id;
   logic [bump_pkg::REQ_BYTES_W-1:0]        request_bytes;

   modport source (output valid, opcode, kind, item_id, request_bytes, input ready);
   modport sink   (input valid, opcode, kind, item_id, request_bytes, output ready);
endinterface

interface bump_rsp_if;
   logic                                    valid;
   logic                                    ready;
   bump_pkg::status_type                    status;
   logic [bump_pkg::ADDR_W-1:0]             address;
   logic [bump_pkg::BYTES_W-1:0]            used_bytes;
   logic [bump_pkg::BYTES_W-1:0]            capacity_bytes;

   modport source (output valid, status, address, used_bytes, capacity_bytes, input ready);
   modport sink   (input valid, status, address, used_bytes, capacity_bytes, output ready);
endinterface

`default_nettype wire

// ===== sv/bump_arena_with_id_registry.sv =====
// ----------------------------------------------------------------------------
// bump_arena_with_id_registry
// Bump-pointer byte arena with a per-kind registry of used ids.
// ----------------------------------------------------------------------------
// Results: close, open and no-op register their result at the request
//   transfer; allocate first reads the registry, then registers its result.
// Rate: one close/open/no-op per cycle while the output register is free or
//   drained; an allocate holds off the next request until its lookup is done.
// Reset: a clearing pass over all KINDS*MAX_IDS entries (1024 at defaults) writes the
//   registry memory; requests wait, configuration writes are taken. The same
//   pass runs again on every 255th close or successful open (tag wrap).
// ----------------------------------------------------------------------------
`default_nettype none

module bump_arena_with_id_registry #(
   parameter int KINDS         = bump_pkg::KINDS_DEF,
   parameter int MAX_IDS       = bump_pkg::MAX_IDS_DEF,
   parameter int MAX_POOL      = bump_pkg::MAX_POOL_DEF,
   parameter int POINTER_BYTES = bump_pkg::POINTER_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   bump_req_if.sink                           req,
   bump_rsp_if.source                         rsp,
   input  logic                               csr_we,
   input  logic [bump_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [bump_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // Registry memory: one generation tag per (kind, id). A mark is set when
   // the stored tag equals the current generation, so emptying the store is
   // a single increment of the generation, plus a sweep when the tag wraps.
   localparam int DEPTH  = KINDS * MAX_IDS;
   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int KSEL_W = (KINDS > 1) ? $clog2(KINDS) : 1;
   localparam int REG_W  = bump_pkg::COUNT_W + 4 + 3;  // registry bytes
   localparam int EPOCH_W = bump_pkg::EPOCH_W;
   localparam int BYTES_W = bump_pkg::BYTES_W;
   localparam int COUNT_W = bump_pkg::COUNT_W;
   localparam int AL_W    = BYTES_W + 1;
   localparam int SUM_W   = BYTES_W + 2;

   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
   localparam logic [SLOT_W-1:0]  SLOT_LAST   = SLOT_W'(DEPTH - 1);

   typedef enum logic [2:0] {
      S_CLEAR  = 3'b001,
      S_IDLE   = 3'b010,
      S_LOOKUP = 3'b100
   } fsm_type;

   // Allocate request held across the registry read
   typedef struct packed {
      bump_pkg::status_type                 status;
      logic                                 reg_id;
      logic [SLOT_W-1:0]                    slot;
      logic [bump_pkg::REQ_BYTES_W-1:0]     size;
   } pend_type;

   fsm_type                       state_ff, state_in;
   logic [BYTES_W-1:0]            pool_size_ff, pool_size_in;
   logic [COUNT_W-1:0]            cfg_count_ff [bump_pkg::CFG_KINDS];
   logic [COUNT_W-1:0]            cfg_count_in [bump_pkg::CFG_KINDS];
   logic [BYTES_W-1:0]            offset_ff, offset_in;
   logic [BYTES_W-1:0]            capacity_ff, capacity_in;
   logic [COUNT_W-1:0]            count_ff [KINDS];
   logic [COUNT_W-1:0]            count_in [KINDS];
   logic [EPOCH_W-1:0]            epoch_ff, epoch_in;
   logic [SLOT_W-1:0]             clr_ptr_ff, clr_ptr_in;
   pend_type                      pend_ff, pend_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   bump_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [bump_pkg::ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [BYTES_W-1:0]            rsp_used_ff, rsp_used_in;
   logic [BYTES_W-1:0]            rsp_cap_ff, rsp_cap_in;

   // Registry memory ports
   logic [EPOCH_W-1:0]            mark_mem [DEPTH];
   logic [EPOCH_W-1:0]            mark_rd_ff;
   logic                          mem_we, mem_re;
   logic [SLOT_W-1:0]             mem_wa, mem_ra;
   logic [EPOCH_W-1:0]            mem_wd;

   // Request handshake
   logic                          accept;

   // Open checks
   logic [COUNT_W-1:0]            open_count [KINDS];
   logic [REG_W-1:0]              reg_bytes;
   logic                          open_ok;

   // Allocate pre-checks
   logic                          kind_ok, is_reg, id_oob;
   logic [KSEL_W-1:0]             ksel;
   logic [COUNT_W-1:0]            kind_count;
   logic [SLOT_W-1:0]             req_slot;

   // Allocate carve
   logic [AL_W-1:0]               aligned;
   logic [SUM_W-1:0]              carve_end;
   logic                          fits, dup;
   bump_pkg::status_type          alloc_status;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp.ready);

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.address        = rsp_addr_ff;
   assign rsp.used_bytes     = rsp_used_ff;
   assign rsp.capacity_bytes = rsp_cap_ff;

   // Configuration writes; indexes past the list are dropped
   always_comb begin
      pool_size_in = pool_size_ff;
      cfg_count_in = cfg_count_ff;
      if (csr_we) begin
         case (csr_addr)
            bump_pkg::CSR_POOL_SIZE: pool_size_in    = csr_wdata;
            bump_pkg::CSR_COUNT_0:   cfg_count_in[0] = csr_wdata[COUNT_W-1:0];
            bump_pkg::CSR_COUNT_1:   cfg_count_in[1] = csr_wdata[COUNT_W-1:0];
            bump_pkg::CSR_COUNT_2:   cfg_count_in[2] = csr_wdata[COUNT_W-1:0];
            bump_pkg::CSR_COUNT_3:   cfg_count_in[3] = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Open: size in range, each count within MAX_IDS, registry fits the pool.
   // Kinds without a count register open with zero ids.
   always_comb begin
      logic count_bad;
      count_bad = 1'b0;
      reg_bytes = '0;
      for (int k = 0; k < KINDS; k++) begin
         open_count[k] = (k < bump_pkg::CFG_KINDS) ?
                         cfg_count_ff[k % bump_pkg::CFG_KINDS] : '0;
         if (32'(open_count[k]) > 32'(MAX_IDS)) begin
            count_bad = 1'b1;
         end
         reg_bytes = reg_bytes + REG_W'(open_count[k]) * REG_W'(POINTER_BYTES);
      end
      open_ok = (pool_size_ff != '0) && (32'(pool_size_ff) <= 32'(MAX_POOL)) &&
                !count_bad && (32'(reg_bytes) <= 32'(pool_size_ff));
   end

   // Allocate pre-checks on the request itself: kind and id bounds
   always_comb begin
      kind_ok    = 32'(req.kind) < 32'(KINDS);
      ksel       = req.kind[KSEL_W-1:0];
      kind_count = kind_ok ? count_ff[ksel] : '0;
      is_reg     = req.item_id != bump_pkg::ID_NONE;
      id_oob     = (32'(req.item_id) >= 32'(kind_count)) ||
                   (32'(req.item_id) >= 32'(MAX_IDS));
      req_slot   = SLOT_W'(32'(ksel) * 32'(MAX_IDS) + 32'(req.item_id));
   end

   // Allocate carve, overflow safe: size <= capacity and aligned + size <= capacity
   always_comb begin
      aligned   = (AL_W'(offset_ff) + AL_W'(bump_pkg::ALIGN_ADD)) &
                  ~AL_W'(bump_pkg::ALIGN_ADD);
      carve_end = SUM_W'(aligned) + SUM_W'(pend_ff.size[AL_W-1:0]);
      fits      = (pend_ff.size <= 32'(capacity_ff)) &&
                  (carve_end <= SUM_W'(capacity_ff));
      dup       = pend_ff.reg_id && (mark_rd_ff == epoch_ff);
      if (pend_ff.status != bump_pkg::ST_OK) begin
         alloc_status = pend_ff.status;
      end else if (dup) begin
         alloc_status = bump_pkg::ST_DUP;
      end else if (capacity_ff == '0 || !fits) begin
         alloc_status = bump_pkg::ST_NO_MEM;
      end else begin
         alloc_status = bump_pkg::ST_OK;
      end
   end

   // Sequencer
   always_comb begin
      logic do_empty;
      do_empty      = 1'b0;
      state_in      = state_ff;
      offset_in     = offset_ff;
      capacity_in   = capacity_ff;
      count_in      = count_ff;
      epoch_in      = epoch_ff;
      clr_ptr_in    = clr_ptr_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_cap_in    = rsp_cap_ff;
      mem_we        = 1'b0;
      mem_wa        = clr_ptr_ff;
      mem_wd        = '0;
      mem_re        = 1'b0;
      mem_ra        = req_slot;

      case (state_ff)
         S_CLEAR: begin
            // Sweep the registry, one entry per cycle
            mem_we     = 1'b1;
            clr_ptr_in = clr_ptr_ff + SLOT_W'(1);
            if (clr_ptr_ff == SLOT_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               rsp_status_in = bump_pkg::ST_OK;
               rsp_addr_in   = '0;
               rsp_used_in   = offset_ff;
               rsp_cap_in    = capacity_ff;
               case (req.opcode)
                  bump_pkg::OP_CLOSE: begin
                     do_empty     = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_used_in  = '0;
                     rsp_cap_in   = '0;
                  end
                  bump_pkg::OP_OPEN: begin
                     rsp_valid_in = 1'b1;
                     if (open_ok) begin
                        // Registry carves are 4-byte multiples and always fit
                        do_empty    = 1'b1;
                        rsp_used_in = BYTES_W'(reg_bytes);
                        rsp_cap_in  = pool_size_ff;
                     end else begin
                        rsp_status_in = bump_pkg::ST_TOO_BIG;
                     end
                  end
                  bump_pkg::OP_ALLOC: begin
                     mem_re         = 1'b1;
                     pend_in.status = (is_reg && (!kind_ok || id_oob)) ?
                                      bump_pkg::ST_OOB : bump_pkg::ST_OK;
                     pend_in.reg_id = is_reg;
                     pend_in.slot   = req_slot;
                     pend_in.size   = req.request_bytes;
                     state_in       = S_LOOKUP;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_LOOKUP: begin
            // Output register was drained at the request transfer
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = alloc_status;
            rsp_addr_in   = '0;
            rsp_used_in   = offset_ff;
            rsp_cap_in    = capacity_ff;
            if (alloc_status == bump_pkg::ST_OK) begin
               offset_in   = BYTES_W'(carve_end);
               rsp_addr_in = aligned[bump_pkg::ADDR_W-1:0];
               rsp_used_in = BYTES_W'(carve_end);
               if (pend_ff.reg_id) begin
                  mem_we = 1'b1;
                  mem_wa = pend_ff.slot;
                  mem_wd = epoch_ff;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_empty) begin
         offset_in   = '0;
         capacity_in = '0;
         for (int k = 0; k < KINDS; k++) begin
            count_in[k] = '0;
         end
         if (req.opcode == bump_pkg::OP_OPEN) begin
            offset_in   = BYTES_W'(reg_bytes);
            capacity_in = pool_size_ff;
            count_in    = open_count;
         end
         // Advance the generation; on wrap, sweep stale tags first
         if (epoch_ff == EPOCH_LAST) begin
            epoch_in   = EPOCH_FIRST;
            clr_ptr_in = '0;
            state_in   = S_CLEAR;
         end else begin
            epoch_in = epoch_ff + EPOCH_W'(1);
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         pool_size_ff <= '0;
         for (int k = 0; k < bump_pkg::CFG_KINDS; k++) begin
            cfg_count_ff[k] <= '0;
         end
         offset_ff    <= '0;
         capacity_ff  <= '0;
         for (int k = 0; k < KINDS; k++) begin
            count_ff[k] <= '0;
         end
         epoch_ff     <= EPOCH_FIRST;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_size_ff <= pool_size_in;
         cfg_count_ff <= cfg_count_in;
         offset_ff    <= offset_in;
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         epoch_ff     <= epoch_in;
         clr_ptr_ff   <= clr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      pend_ff       <= pend_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_cap_ff    <= rsp_cap_in;
   end

   // Registry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mark_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mark_rd_ff <= mark_mem[mem_ra];
      end
   end

   // Checks
   a_used_le_cap: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.used_bytes <= rsp.capacity_bytes)
      else $error("used bytes exceed capacity");

   a_addr_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.address[1:0] == 2'b00)
      else $error("carved address not 4-byte aligned");

   a_err_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != bump_pkg::ST_OK) |-> rsp.address == '0)
      else $error("error result carries an address");

   a_alloc_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req.opcode == bump_pkg::OP_ALLOC) |=> ##1 rsp_valid_ff)
      else $error("allocate result not produced after lookup");

   a_epoch_live: assert property (@(posedge clock) disable iff (reset)
      epoch_ff != '0)
      else $error("generation tag collides with cleared tag");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the bump arena with its id registry against an in-line predictor:
// a table of directed transfers (closed store, open failures, pool and id
// extremes, duplicate and out-of-range ids), then random phases of opens,
// allocates, closes and no-ops, each phase behind a fresh register setting.
// Both channels idle in random bursts; one long response hold fills the block.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bump_pkg::*;

   localparam int RANDOM_ITEMS = 525;
   localparam int CALM_FROM    = 465;  // no idling on either side from here on
   localparam int LONG_HOLD    = 200;  // length of the one long response hold
   localparam int HOLD_PHASE   = 3;

   typedef struct packed {
      status_type               status;
      logic [ADDR_W-1:0]        address;
      logic [BYTES_W-1:0]       used_bytes;
      logic [BYTES_W-1:0]       capacity_bytes;
   } outcome_type;

   // One row of the directed table: either a register setting or a transfer,
   // the latter optionally with its result typed in.
   typedef struct packed {
      bit                                   is_cfg;
      logic [BYTES_W-1:0]                   pool;
      logic [CFG_KINDS-1:0][COUNT_W-1:0]    counts;
      opcode_type                           op;
      logic [KIND_W-1:0]                    kind;
      logic [ID_W-1:0]                      item_id;
      logic [REQ_BYTES_W-1:0]               nbytes;
      bit                                   fixed;
      outcome_type                          want;
   } plan_row_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_we;
   logic [CSR_IDX_W-1:0]    csr_addr;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   bump_req_if req_bus ();
   bump_rsp_if rsp_bus ();

   bump_arena_with_id_registry u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Arena predictor: register copies and store state
   // -------------------------------------------------------------------------
   logic [BYTES_W-1:0]  pool_reg;
   logic [COUNT_W-1:0]  count_reg [CFG_KINDS];
   logic [BYTES_W-1:0]  arena_offset;
   logic [BYTES_W-1:0]  arena_cap;
   logic [COUNT_W-1:0]  live_counts [KINDS_DEF];
   bit                  id_taken [KINDS_DEF][MAX_IDS_DEF];

   outcome_type   outcomes_due [$];   // results owed by the block, oldest first
   plan_row_type  plan [$];
   int            errors = 0;
   bit            calm = 1'b0;
   bit            hold_rsp = 1'b0;

   function automatic void cfg_write(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      if (idx == CSR_POOL_SIZE)
         pool_reg = data[BYTES_W-1:0];
      else if (idx >= CSR_COUNT_0 && idx <= CSR_COUNT_3)
         count_reg[idx - CSR_COUNT_0] = data[COUNT_W-1:0];
   endfunction

   function automatic void store_clear();
      arena_offset = '0;
      arena_cap    = '0;
      foreach (live_counts[k]) live_counts[k] = '0;
      foreach (id_taken[k, i]) id_taken[k][i] = 1'b0;
   endfunction

   // Bump the offset by size at 4-byte alignment; never wraps past capacity.
   function automatic bit carve_bytes(input int unsigned size, output int unsigned where);
      int unsigned aligned;
      int unsigned cap;
      cap     = 32'(arena_cap);
      aligned = (32'(arena_offset) + 32'(ALIGN_ADD)) & ~32'(ALIGN_ADD);
      where   = 0;
      if (size > cap || aligned > cap - size)
         return 1'b0;
      arena_offset = BYTES_W'(aligned + size);
      where = aligned;
      return 1'b1;
   endfunction

   function automatic status_type store_open();
      int unsigned reg_bytes;
      int unsigned where;
      reg_bytes = 0;
      if (pool_reg == 0 || pool_reg > MAX_POOL_DEF)
         return ST_TOO_BIG;
      for (int k = 0; k < KINDS_DEF; k++) begin
         if (count_reg[k] > MAX_IDS_DEF)
            return ST_TOO_BIG;
         reg_bytes += count_reg[k] * POINTER_BYTES_DEF;
      end
      if (reg_bytes > pool_reg)
         return ST_TOO_BIG;
      store_clear();
      arena_cap = pool_reg;
      for (int k = 0; k < KINDS_DEF; k++) begin
         live_counts[k] = count_reg[k];
         if (count_reg[k] != 0)
            void'(carve_bytes(count_reg[k] * POINTER_BYTES_DEF, where));
      end
      return ST_OK;
   endfunction

   function automatic status_type store_alloc(input logic [KIND_W-1:0] kind,
                                              input logic [ID_W-1:0] item_id,
                                              input logic [REQ_BYTES_W-1:0] nbytes,
                                              output int unsigned where);
      bit registered;
      registered = 1'b0;
      where = 0;
      if (item_id != ID_NONE) begin
         if (kind >= KINDS_DEF)
            return ST_OOB;
         if (item_id >= live_counts[kind] || item_id >= MAX_IDS_DEF)
            return ST_OOB;
         if (id_taken[kind][item_id])
            return ST_DUP;
         registered = 1'b1;
      end
      if (arena_cap == 0)
         return ST_NO_MEM;
      if (!carve_bytes(nbytes, where))
         return ST_NO_MEM;
      if (registered)
         id_taken[kind][item_id] = 1'b1;
      return ST_OK;
   endfunction

   // Apply one request to the predicted store and return the result it owes.
   function automatic outcome_type arena_apply(input opcode_type op,
                                               input logic [KIND_W-1:0] kind,
                                               input logic [ID_W-1:0] item_id,
                                               input logic [REQ_BYTES_W-1:0] nbytes);
      status_type   st;
      int unsigned  where;
      outcome_type  res;
      st    = ST_OK;
      where = 0;
      case (op)
         OP_CLOSE: store_clear();
         OP_OPEN:  st = store_open();
         OP_ALLOC: st = store_alloc(kind, item_id, nbytes, where);
         default:  ;
      endcase
      if (st != ST_OK)
         where = 0;
      res.status         = st;
      res.address        = where[ADDR_W-1:0];
      res.used_bytes     = arena_offset;
      res.capacity_bytes = arena_cap;
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Directed table builders
   // -------------------------------------------------------------------------
   function automatic void plan_cfg(input int pool, input int c0, input int c1,
                                    input int c2, input int c3);
      plan_row_type row;
      row        = '0;
      row.is_cfg = 1'b1;
      row.pool   = BYTES_W'(pool);
      row.counts = {COUNT_W'(c3), COUNT_W'(c2), COUNT_W'(c1), COUNT_W'(c0)};
      plan.push_back(row);
   endfunction

   function automatic void plan_fixed(input opcode_type op, input int kind,
                                      input int item_id, input longint nbytes,
                                      input bit fixed, input status_type st,
                                      input int addr, input int used, input int cap);
      plan_row_type row;
      row                     = '0;
      row.op                  = op;
      row.kind                = KIND_W'(kind);
      row.item_id             = ID_W'(item_id);
      row.nbytes              = REQ_BYTES_W'(nbytes);
      row.fixed               = fixed;
      row.want.status         = st;
      row.want.address        = ADDR_W'(addr);
      row.want.used_bytes     = BYTES_W'(used);
      row.want.capacity_bytes = BYTES_W'(cap);
      plan.push_back(row);
   endfunction

   function automatic void plan_op(input opcode_type op, input int kind,
                                   input int item_id, input longint nbytes);
      plan_fixed(op, kind, item_id, nbytes, 1'b0, ST_OK, 0, 0, 0);
   endfunction

   // -------------------------------------------------------------------------
   // Drivers: all inputs change at the falling edge
   // -------------------------------------------------------------------------

   // Write every register once; hold the write enable across the burst so it
   // sees one assignment per step.
   task automatic apply_config(input logic [BYTES_W-1:0] pool,
                               input logic [CFG_KINDS-1:0][COUNT_W-1:0] counts,
                               input bit noisy);
      logic [CSR_DATA_W-1:0] data;
      csr_we    <= 1'b1;
      csr_addr  <= CSR_POOL_SIZE;
      csr_wdata <= pool;
      cfg_write(CSR_POOL_SIZE, pool);
      @(negedge clock);
      for (int k = 0; k < CFG_KINDS; k++) begin
         data = CSR_DATA_W'(counts[k]);
         // Upper write-data bits past a count register are dropped by the block
         if (noisy)
            data[CSR_DATA_W-1:COUNT_W] = (CSR_DATA_W - COUNT_W)'($urandom);
         csr_addr  <= CSR_IDX_W'(CSR_COUNT_0 + k);
         csr_wdata <= data;
         cfg_write(CSR_IDX_W'(CSR_COUNT_0 + k), data);
         @(negedge clock);
      end
      if (noisy) begin
         // Hit an unmapped index; it must change nothing
         data = CSR_DATA_W'($urandom);
         csr_addr  <= CSR_IDX_W'(CSR_COUNT_3 + $urandom_range(1, 3));
         csr_wdata <= data;
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Offer one request, wait for its transfer, record the result it owes.
   // Enter and leave at a falling edge; valid stays high on exit.
   task automatic send_item(input opcode_type op, input logic [KIND_W-1:0] kind,
                            input logic [ID_W-1:0] item_id,
                            input logic [REQ_BYTES_W-1:0] nbytes,
                            input bit fixed, input outcome_type want);
      int           gap;
      outcome_type  got;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.opcode        <= op;
      req_bus.kind          <= kind;
      req_bus.item_id       <= item_id;
      req_bus.request_bytes <= nbytes;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      got = arena_apply(op, kind, item_id, nbytes);
      outcomes_due.push_back(fixed ? want : got);
      @(negedge clock);
   endtask

   // Drop valid and wait until every owed result has come back.
   task automatic finish_phase();
      req_bus.valid <= 1'b0;
      while (outcomes_due.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      end
   endtask

   // -------------------------------------------------------------------------
   // Response side: pace ready in bursts, and hold off once for a long stretch
   // -------------------------------------------------------------------------
   initial begin : rsp_pacer
      int stall;
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            // Hold off long enough that the block backs up into its input
            hold_rsp = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 11);
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Compare every response transfer with the oldest owed result.
   always @(posedge clock) begin : rsp_check
      outcome_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (outcomes_due.size() == 0) begin
            errors++;
            $display("%0t: result with none owed, expected nothing, got status %0d",
                     $time, rsp_bus.status);
         end else begin
            want = outcomes_due.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_bus.status));
            check_field("address", 32'(want.address), 32'(rsp_bus.address));
            check_field("used_bytes", 32'(want.used_bytes),
                        32'(rsp_bus.used_bytes));
            check_field("capacity_bytes", 32'(want.capacity_bytes),
                        32'(rsp_bus.capacity_bytes));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int                                 sent;
      int                                 phase;
      int                                 n;
      int                                 r;
      int                                 mode;
      int                                 cnt;
      int                                 reg_bytes;
      int                                 near;
      logic [BYTES_W-1:0]                 pool;
      logic [CFG_KINDS-1:0][COUNT_W-1:0]  counts;
      opcode_type                         op;
      logic [KIND_W-1:0]                  kind;
      logic [ID_W-1:0]                    item_id;
      logic [REQ_BYTES_W-1:0]             nbytes;
      bit                                 noisy;
      outcome_type                        none;

      none = '0;
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_addr              = CSR_POOL_SIZE;
      csr_wdata             = '0;
      req_bus.valid         = 1'b0;
      req_bus.opcode        = OP_NOP;
      req_bus.kind          = '0;
      req_bus.item_id       = '0;
      req_bus.request_bytes = '0;
      pool_reg              = '0;
      foreach (count_reg[k]) count_reg[k] = '0;
      store_clear();

      // Directed table. Rows with a result typed in are read straight off the
      // arena rules; the rest go through the predictor.
      // Closed store after reset: unregistered allocate, registered id, no-op
      plan_fixed(OP_ALLOC, 0, ID_NONE, 0, 1, ST_NO_MEM, 0, 0, 0);
      plan_fixed(OP_ALLOC, 0, 0, 4, 1, ST_OOB, 0, 0, 0);
      plan_fixed(OP_NOP, 255, 'h1234, 'hFFFF_FFFF, 1, ST_OK, 0, 0, 0);
      // Open failures: zero pool, pool above the maximum, all-ones pool,
      // count above the id limit, registry larger than the pool
      plan_fixed(OP_OPEN, 0, 0, 0, 1, ST_TOO_BIG, 0, 0, 0);
      plan_cfg(65537, 0, 0, 0, 0);
      plan_fixed(OP_OPEN, 0, 0, 0, 1, ST_TOO_BIG, 0, 0, 0);
      plan_cfg(131071, 0, 0, 0, 0);
      plan_fixed(OP_OPEN, 0, 0, 0, 1, ST_TOO_BIG, 0, 0, 0);
      plan_cfg(100, 257, 0, 0, 0);
      plan_fixed(OP_OPEN, 0, 0, 0, 1, ST_TOO_BIG, 0, 0, 0);
      plan_cfg(16, 1, 1, 1, 2);
      plan_fixed(OP_OPEN, 0, 0, 0, 1, ST_TOO_BIG, 0, 0, 0);
      // Largest pool, full registry on every kind
      plan_cfg(65536, 256, 256, 256, 256);
      plan_fixed(OP_OPEN, 0, 0, 0, 1, ST_OK, 0, 4096, 65536);
      plan_fixed(OP_ALLOC, 0, 255, 1, 1, ST_OK, 4096, 4097, 65536);
      plan_fixed(OP_ALLOC, 0, 255, 1, 1, ST_DUP, 0, 4097, 65536);
      plan_fixed(OP_ALLOC, 3, 256, 1, 1, ST_OOB, 0, 4097, 65536);
      plan_fixed(OP_ALLOC, 4, 0, 1, 1, ST_OOB, 0, 4097, 65536);
      plan_fixed(OP_ALLOC, 255, 'hFFFE, 1, 1, ST_OOB, 0, 4097, 65536);
      // Unregistered allocate ignores the kind; then huge, exact-fit, empty
      plan_fixed(OP_ALLOC, 255, ID_NONE, 3, 1, ST_OK, 4100, 4103, 65536);
      plan_fixed(OP_ALLOC, 0, ID_NONE, 'hFFFF_FFFF, 1, ST_NO_MEM, 0, 4103, 65536);
      plan_fixed(OP_ALLOC, 2, 0, 61432, 1, ST_OK, 4104, 65536, 65536);
      plan_fixed(OP_ALLOC, 1, 7, 0, 1, ST_OK, 0, 65536, 65536);
      plan_fixed(OP_ALLOC, 1, 8, 1, 1, ST_NO_MEM, 0, 65536, 65536);
      plan_fixed(OP_CLOSE, 0, 0, 0, 1, ST_OK, 0, 0, 0);
      plan_fixed(OP_ALLOC, 1, 8, 1, 1, ST_OOB, 0, 0, 0);
      // Registry exactly fills the pool; a failed open keeps state and marks
      plan_cfg(4, 1, 0, 0, 0);
      plan_fixed(OP_OPEN, 0, 0, 0, 1, ST_OK, 0, 4, 4);
      plan_op(OP_ALLOC, 0, 0, 0);
      plan_cfg(0, 0, 0, 0, 0);
      plan_fixed(OP_OPEN, 0, 0, 0, 1, ST_TOO_BIG, 0, 4, 4);
      plan_op(OP_ALLOC, 0, 0, 0);

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            finish_phase();
            apply_config(plan[i].pool, plan[i].counts, 1'b0);
         end else begin
            send_item(plan[i].op, plan[i].kind, plan[i].item_id, plan[i].nbytes,
                      plan[i].fixed, plan[i].want);
         end
      end

      // Random phases: new registers, an open, then mostly well-formed
      // allocates against the live counts, with noise mixed in.
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         finish_phase();
         mode = $urandom_range(0, 9);
         for (int k = 0; k < CFG_KINDS; k++)
            counts[k] = COUNT_W'($urandom_range(0, 24));
         reg_bytes = 0;
         for (int k = 0; k < CFG_KINDS; k++)
            reg_bytes += counts[k] * POINTER_BYTES_DEF;
         case (mode)
            0: begin
               pool = BYTES_W'(MAX_POOL_DEF);
               for (int k = 0; k < CFG_KINDS; k++)
                  counts[k] = COUNT_W'(MAX_IDS_DEF);
            end
            1: begin
               // Bad setting of one sort or another
               case ($urandom_range(0, 3))
                  0: pool = '0;
                  1: pool = BYTES_W'($urandom_range(MAX_POOL_DEF + 1, 131071));
                  2: begin
                     pool = BYTES_W'(MAX_POOL_DEF);
                     counts[$urandom_range(0, CFG_KINDS - 1)] =
                        COUNT_W'($urandom_range(MAX_IDS_DEF + 1, 511));
                  end
                  default: begin
                     for (int k = 0; k < CFG_KINDS; k++)
                        counts[k] = COUNT_W'($urandom_range(1, 20));
                     reg_bytes = 0;
                     for (int k = 0; k < CFG_KINDS; k++)
                        reg_bytes += counts[k] * POINTER_BYTES_DEF;
                     pool = BYTES_W'($urandom_range(1, reg_bytes - 1));
                  end
               endcase
            end
            2: begin
               pool   = BYTES_W'(1);
               counts = '0;
            end
            default: begin
               if ($urandom_range(0, 3) == 0)
                  pool = BYTES_W'(reg_bytes + $urandom_range(0, MAX_POOL_DEF - reg_bytes));
               else
                  pool = BYTES_W'(reg_bytes + $urandom_range(0, 600));
               if (pool == 0)
                  pool = BYTES_W'(1);
            end
         endcase
         noisy = ($urandom_range(0, 3) == 0);
         apply_config(pool, counts, noisy);
         if (phase == HOLD_PHASE)
            hold_rsp = 1'b1;
         phase++;

         send_item(OP_OPEN, KIND_W'($urandom), ID_W'($urandom), $urandom, 1'b0, none);
         sent++;
         n = $urandom_range(15, 40);
         for (int j = 0; j < n && sent < RANDOM_ITEMS; j++) begin
            calm    = (sent >= CALM_FROM);
            op      = OP_ALLOC;
            kind    = KIND_W'($urandom);
            item_id = ID_W'($urandom);
            nbytes  = $urandom;
            r = $urandom_range(0, 99);
            if (r < 55) begin
               // Well-formed allocate: live kind, fresh-looking or no id
               kind = KIND_W'($urandom_range(0, KINDS_DEF - 1));
               cnt  = live_counts[kind];
               if (cnt == 0 || $urandom_range(0, 2) == 0)
                  item_id = ID_NONE;
               else
                  item_id = ID_W'($urandom_range(0, cnt - 1));
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: nbytes = $urandom_range(0, 40);
                  6, 7, 8:          nbytes = $urandom_range(0, 600);
                  default:          nbytes = $urandom;
               endcase
            end else if (r < 63) begin
               // Noise: all fields random
            end else if (r < 70) begin
               // Id on either side of the live count
               kind    = KIND_W'($urandom_range(0, KINDS_DEF - 1));
               cnt     = live_counts[kind];
               item_id = ID_W'((cnt > 0 && $urandom_range(0, 1) == 0) ? cnt - 1 : cnt);
               nbytes  = $urandom_range(0, 16);
            end else if (r < 76) begin
               op = OP_OPEN;
            end else if (r < 81) begin
               op = OP_CLOSE;
            end else if (r < 86) begin
               op = OP_NOP;
            end else begin
               // Size right around what is left in the pool
               item_id = ID_NONE;
               near    = int'(arena_cap) - int'(arena_offset)
                         + int'($urandom_range(0, 6)) - 3;
               nbytes  = REQ_BYTES_W'(near);
            end
            send_item(op, kind, item_id, nbytes, 1'b0, none);
            sent++;
         end
      end

      // Drain, then give any stray result time to show up
      finish_phase();
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin : watchdog
      #4_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/bump_pkg.sv
sv/bump_ifs.sv
sv/bump_arena_with_id_registry.sv
test/testbench.sv
